// File: rtl/core/wtc_pkg.sv
// Package: widths, codes and shared types of the whitespace token classifier.
`timescale 1ns / 1ps

package wtc_pkg;

  // Field widths
  localparam int LINE_BITS      = 16;
  localparam int COLUMN_BITS    = 12;
  localparam int LENGTH_BITS    = 8;
  localparam int BYTE_BITS      = 8;
  localparam int CLASS_BITS     = 3;
  localparam int START_LINE_BITS   = 16;
  localparam int START_COLUMN_BITS = 12;
  localparam int CFG_DATA_BITS  = 16;
  localparam int CFG_INDEX_BITS = 1;

  // Configuration register indexes
  localparam logic [CFG_INDEX_BITS-1:0] CFG_START_LINE   = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_START_COLUMN = 1'b1;

  // Token classes as given on the result channel
  typedef enum logic [CLASS_BITS-1:0] {
    CLS_CHAR  = 3'd0,
    CLS_HEX   = 3'd1,
    CLS_WORD  = 3'd2,
    CLS_FLOAT = 3'd3,
    CLS_INT   = 3'd4,
    CLS_NONE  = 3'd5
  } token_class_t;

  // Class tracker states while a token is open
  typedef enum logic [2:0] {
    TR_FIRST = 3'd0,
    TR_ZERO  = 3'd1,
    TR_MINUS = 3'd2,
    TR_NUM   = 3'd3,
    TR_HEX   = 3'd4,
    TR_WORD  = 3'd5
  } tracker_t;

  // One configuration write
  typedef struct packed {
    logic                      we;
    logic [CFG_INDEX_BITS-1:0] index;
    logic [CFG_DATA_BITS-1:0]  data;
  } cfg_write_t;

  // One result transaction
  typedef struct packed {
    token_class_t           token_class;
    logic [LINE_BITS-1:0]   token_line;
    logic [COLUMN_BITS-1:0] token_column;
    logic [LENGTH_BITS-1:0] token_length;
    logic                   end_of_input;
  } token_result_t;

endpackage

// File: rtl/core/wtc_channels.sv
// Interfaces: text byte channel and token result channel.
`timescale 1ns / 1ps

interface wtc_byte_if;
  logic                          valid;
  logic                          ready;
  logic [wtc_pkg::BYTE_BITS-1:0] text_byte;

  modport source (output valid, output text_byte, input ready);
  modport sink (input valid, input text_byte, output ready);
endinterface

interface wtc_token_if;
  logic                            valid;
  logic                            ready;
  logic [wtc_pkg::CLASS_BITS-1:0]  token_class;
  logic [wtc_pkg::LINE_BITS-1:0]   token_line;
  logic [wtc_pkg::COLUMN_BITS-1:0] token_column;
  logic [wtc_pkg::LENGTH_BITS-1:0] token_length;
  logic                            end_of_input;

  modport source (output valid, output token_class, output token_line,
                  output token_column, output token_length, output end_of_input,
                  input ready);
  modport sink (input valid, input token_class, input token_line,
                input token_column, input token_length, input end_of_input,
                output ready);
endinterface

// File: rtl/core/whitespace_token_classifier_top.sv
// Whitespace token classifier: one text byte per cycle in, at most one
// token transaction out per byte. A byte is held in an input register, is
// processed by the tokenizer state once the output register can take its
// result, and a closing token lands in that output register. With the result
// side ready the block takes one byte every cycle; a stalled result holds the
// input register, which then fills and drops ready. Whitespace (space, tab,
// newline, vertical tab, form feed,
// carriage return) closes a token; a zero byte ends input, always gives a
// result and reloads the line and column from start_line and start_column.
`timescale 1ns / 1ps

module whitespace_token_classifier_top (
  input  logic                                 clk,
  input  logic                                 rst,
  wtc_byte_if.sink                             text,
  wtc_token_if.source                          token,
  input  logic                                 cfg_we,
  input  logic [wtc_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [wtc_pkg::CFG_DATA_BITS-1:0]    cfg_wdata
);

  logic                           in_valid;
  logic [wtc_pkg::BYTE_BITS-1:0]  in_byte;
  logic                           out_valid;
  wtc_pkg::token_result_t         out_data;
  logic                           advance;
  logic                           emit;
  wtc_pkg::token_result_t         result;
  wtc_pkg::cfg_write_t            cfg;

  assign cfg.we    = cfg_we;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_wdata;

  // Move the held byte on when the output register can take its result
  assign advance    = in_valid && (!out_valid || token.ready);
  assign text.ready = !in_valid || advance;

  // Hold the input byte
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (text.ready) begin
      in_valid <= text.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (text.valid && text.ready) begin
      in_byte <= text.text_byte;
    end
  end

  wtc_core u_core (
    .clk       (clk),
    .rst       (rst),
    .fire      (advance),
    .text_byte (in_byte),
    .cfg       (cfg),
    .emit      (emit),
    .result    (result)
  );

  // Hold the result until the transaction completes
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (token.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data <= result;
    end
  end

  assign token.valid        = out_valid;
  assign token.token_class  = out_data.token_class;
  assign token.token_line   = out_data.token_line;
  assign token.token_column = out_data.token_column;
  assign token.token_length = out_data.token_length;
  assign token.end_of_input = out_data.end_of_input;

endmodule

// File: rtl/core/wtc_core.sv
// Tokenizer state: position counters, open token tracking and classification.
`timescale 1ns / 1ps

module wtc_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                fire,
  input  logic [wtc_pkg::BYTE_BITS-1:0]       text_byte,
  input  wtc_pkg::cfg_write_t                 cfg,
  output logic                                emit,
  output wtc_pkg::token_result_t              result
);

  localparam logic [wtc_pkg::LINE_BITS-1:0]   LineMax = '1;
  localparam logic [wtc_pkg::COLUMN_BITS-1:0] ColMax  = '1;
  localparam logic [wtc_pkg::LENGTH_BITS-1:0] LenMax  = '1;
  localparam logic [wtc_pkg::LENGTH_BITS-1:0] LenTwo  = wtc_pkg::LENGTH_BITS'(2);
  localparam logic [wtc_pkg::LENGTH_BITS-1:0] LenThree = wtc_pkg::LENGTH_BITS'(3);

  function automatic logic is_ws(input logic [7:0] b);
    return (b == 8'h20) || (b >= 8'd9 && b <= 8'd13);
  endfunction

  function automatic logic is_dig(input logic [7:0] b);
    return (b >= "0") && (b <= "9");
  endfunction

  function automatic logic is_hexdig(input logic [7:0] b);
    return is_dig(b) || (b >= "a" && b <= "f") || (b >= "A" && b <= "F");
  endfunction

  // Registers
  logic [wtc_pkg::START_LINE_BITS-1:0]   start_line;
  logic [wtc_pkg::START_COLUMN_BITS-1:0] start_column;
  logic [wtc_pkg::LINE_BITS-1:0]         line_count, line_count_next;
  logic [wtc_pkg::COLUMN_BITS-1:0]       column_count, column_count_next;
  logic [wtc_pkg::LINE_BITS-1:0]         tok_line, tok_line_next;
  logic [wtc_pkg::COLUMN_BITS-1:0]       tok_column, tok_column_next;
  logic [wtc_pkg::LENGTH_BITS-1:0]       length, length_next;
  wtc_pkg::tracker_t                     tracker, tracker_next;
  logic [1:0]                            dots, dots_next;
  logic [1:0]                            quotes, quotes_next;
  logic                                  fresh, fresh_next;

  logic                                  is_end;
  logic                                  is_space;
  logic                                  open;
  wtc_pkg::token_class_t                 final_class;

  assign is_end   = (text_byte == 8'h00);
  assign is_space = is_ws(text_byte);
  assign open     = (length != '0);

  // Classify the open token from its tracked state
  always_comb begin
    if (quotes == 2'b11) begin
      final_class = wtc_pkg::CLS_CHAR;
    end else begin
      unique case (tracker)
        wtc_pkg::TR_ZERO: final_class = wtc_pkg::CLS_INT;
        wtc_pkg::TR_HEX:  final_class = wtc_pkg::CLS_HEX;
        wtc_pkg::TR_NUM: begin
          if (dots == 2'd0)      final_class = wtc_pkg::CLS_INT;
          else if (dots == 2'd1) final_class = wtc_pkg::CLS_FLOAT;
          else                   final_class = wtc_pkg::CLS_WORD;
        end
        default: final_class = wtc_pkg::CLS_WORD;
      endcase
    end
  end

  // Build the result and the emit flag
  always_comb begin
    emit = fire && (is_end || (is_space && open));
    if (is_end && !open) begin
      result.token_class  = wtc_pkg::CLS_NONE;
      result.token_line   = line_count;
      result.token_column = column_count;
      result.token_length = '0;
    end else begin
      result.token_class  = final_class;
      result.token_line   = tok_line;
      result.token_column = tok_column;
      result.token_length = length;
    end
    result.end_of_input = is_end;
  end

  // Next state for one accepted byte or a configuration write
  always_comb begin
    line_count_next   = line_count;
    column_count_next = column_count;
    tok_line_next     = tok_line;
    tok_column_next   = tok_column;
    length_next       = length;
    tracker_next      = tracker;
    dots_next         = dots;
    quotes_next       = quotes;
    fresh_next        = fresh;

    if (fire) begin
      if (is_end) begin
        // close everything and restart position
        length_next       = '0;
        tracker_next      = wtc_pkg::TR_FIRST;
        dots_next         = 2'd0;
        quotes_next       = 2'd0;
        line_count_next   = wtc_pkg::LINE_BITS'(start_line);
        column_count_next = wtc_pkg::COLUMN_BITS'(start_column);
        fresh_next        = 1'b1;
      end else begin
        fresh_next = 1'b0;
        if (is_space) begin
          length_next  = '0;
          tracker_next = wtc_pkg::TR_FIRST;
          dots_next    = 2'd0;
          quotes_next  = 2'd0;
        end else begin
          if (!open) begin
            tok_line_next   = line_count;
            tok_column_next = column_count;
          end
          // advance the class tracker
          unique case (tracker)
            wtc_pkg::TR_FIRST: begin
              if (text_byte == "0")      tracker_next = wtc_pkg::TR_ZERO;
              else if (text_byte == "-") tracker_next = wtc_pkg::TR_MINUS;
              else if (is_dig(text_byte)) tracker_next = wtc_pkg::TR_NUM;
              else                       tracker_next = wtc_pkg::TR_WORD;
            end
            wtc_pkg::TR_ZERO: begin
              if (text_byte == "x" || text_byte == "X" ||
                  text_byte == "b" || text_byte == "B") begin
                tracker_next = wtc_pkg::TR_HEX;
              end else if (is_dig(text_byte)) begin
                tracker_next = wtc_pkg::TR_NUM;
              end else if (text_byte == ".") begin
                tracker_next = wtc_pkg::TR_NUM;
                dots_next    = 2'd1;
              end else begin
                tracker_next = wtc_pkg::TR_WORD;
              end
            end
            wtc_pkg::TR_MINUS: begin
              tracker_next = is_dig(text_byte) ? wtc_pkg::TR_NUM : wtc_pkg::TR_WORD;
            end
            wtc_pkg::TR_NUM: begin
              if (text_byte == ".") begin
                if (dots != 2'd2) dots_next = dots + 2'd1;
              end else if (!is_dig(text_byte)) begin
                tracker_next = wtc_pkg::TR_WORD;
              end
            end
            wtc_pkg::TR_HEX: begin
              if (!is_hexdig(text_byte)) tracker_next = wtc_pkg::TR_WORD;
            end
            default: tracker_next = wtc_pkg::TR_WORD;
          endcase
          // track the quote pattern of a char literal
          if (length == '0 && text_byte == "'")        quotes_next = quotes | 2'b01;
          else if (length == LenTwo && text_byte == "'") quotes_next = quotes | 2'b10;
          else if (length >= LenThree)                  quotes_next = 2'b00;
          if (length != LenMax) length_next = length + 1'b1;
        end
        // advance position
        if (text_byte == 8'h0A) begin
          column_count_next = '0;
          if (line_count != LineMax) line_count_next = line_count + 1'b1;
        end else if (column_count != ColMax) begin
          column_count_next = column_count + 1'b1;
        end
      end
    end else if (cfg.we && fresh) begin
      // before any byte since reset or end of input, a new start value takes effect at once
      if (cfg.index == wtc_pkg::CFG_START_LINE) begin
        line_count_next = wtc_pkg::LINE_BITS'(cfg.data[wtc_pkg::START_LINE_BITS-1:0]);
      end else begin
        column_count_next =
          wtc_pkg::COLUMN_BITS'(cfg.data[wtc_pkg::START_COLUMN_BITS-1:0]);
      end
    end
  end

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      start_line   <= wtc_pkg::START_LINE_BITS'(1);
      start_column <= '0;
    end else if (cfg.we) begin
      if (cfg.index == wtc_pkg::CFG_START_LINE) begin
        start_line <= cfg.data[wtc_pkg::START_LINE_BITS-1:0];
      end else begin
        start_column <= cfg.data[wtc_pkg::START_COLUMN_BITS-1:0];
      end
    end
  end

  // Hold tokenizer state
  always_ff @(posedge clk) begin
    if (rst) begin
      line_count   <= wtc_pkg::LINE_BITS'(1);
      column_count <= '0;
      tok_line     <= '0;
      tok_column   <= '0;
      length       <= '0;
      tracker      <= wtc_pkg::TR_FIRST;
      dots         <= 2'd0;
      quotes       <= 2'd0;
      fresh        <= 1'b1;
    end else begin
      line_count   <= line_count_next;
      column_count <= column_count_next;
      tok_line     <= tok_line_next;
      tok_column   <= tok_column_next;
      length       <= length_next;
      tracker      <= tracker_next;
      dots         <= dots_next;
      quotes       <= quotes_next;
      fresh        <= fresh_next;
    end
  end

endmodule

// File: dv/token_checker.sv
// Checker: predicts token transactions from the byte and config traffic and compares them.
`timescale 1ns / 1ps

module token_checker
  import wtc_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  wtc_byte_if                       text,
  wtc_token_if                      token,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_wdata,
  output int                        failures,
  output int                        pending
);

  localparam logic [7:0] TAB        = 8'h09;
  localparam logic [7:0] NEWLINE    = 8'h0A;
  localparam logic [7:0] CR         = 8'h0D;
  localparam logic [7:0] SPACE      = 8'h20;
  localparam logic [7:0] QUOTE      = 8'h27;
  localparam logic [7:0] MINUS      = 8'h2D;
  localparam logic [7:0] DOT        = 8'h2E;
  localparam logic [7:0] DIGIT_ZERO = 8'h30;
  localparam logic [7:0] DIGIT_NINE = 8'h39;
  localparam logic [7:0] UPPER_B    = 8'h42;
  localparam logic [7:0] UPPER_X    = 8'h58;
  localparam logic [7:0] LOWER_B    = 8'h62;
  localparam logic [7:0] LOWER_X    = 8'h78;
  localparam int         REPORT_MAX = 10;

  // Start values from the config registers
  logic [START_LINE_BITS-1:0]   first_line;
  logic [START_COLUMN_BITS-1:0] first_column;
  // Position counters
  logic [LINE_BITS-1:0]         line_now;
  logic [COLUMN_BITS-1:0]       column_now;
  // Token being collected
  logic [LINE_BITS-1:0]         open_line;
  logic [COLUMN_BITS-1:0]       open_column;
  logic [LENGTH_BITS-1:0]       open_length;
  tracker_t                     shape;
  logic [1:0]                   dots;
  logic [1:0]                   quotes;
  logic                         fresh;

  token_result_t expected_tokens[$];
  int            mismatch_count = 0;

  function automatic logic is_space(input logic [7:0] b);
    return b == SPACE || (b >= TAB && b <= CR);
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return b >= DIGIT_ZERO && b <= DIGIT_NINE;
  endfunction

  function automatic logic is_hex_digit(input logic [7:0] b);
    return is_digit(b) || (b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46);
  endfunction

  function automatic token_class_t classify();
    if (quotes == 2'b11) return CLS_CHAR;
    case (shape)
      TR_ZERO: return CLS_INT;
      TR_HEX:  return CLS_HEX;
      TR_NUM: begin
        if (dots == 2'd0) return CLS_INT;
        if (dots == 2'd1) return CLS_FLOAT;
        return CLS_WORD;
      end
      default: return CLS_WORD;
    endcase
  endfunction

  function automatic token_result_t close_token(input logic at_end);
    token_result_t r;
    r.token_class  = classify();
    r.token_line   = open_line;
    r.token_column = open_column;
    r.token_length = open_length;
    r.end_of_input = at_end;
    return r;
  endfunction

  task automatic clear_open();
    open_length = '0;
    shape       = TR_FIRST;
    dots        = '0;
    quotes      = '0;
  endtask

  // Update class tracking, quote detection and length for one token byte
  task automatic track(input logic [7:0] b);
    case (shape)
      TR_FIRST: begin
        if (b == DIGIT_ZERO) shape = TR_ZERO;
        else if (b == MINUS) shape = TR_MINUS;
        else if (is_digit(b)) shape = TR_NUM;
        else shape = TR_WORD;
      end
      TR_ZERO: begin
        if (b == LOWER_X || b == UPPER_X || b == LOWER_B || b == UPPER_B) begin
          shape = TR_HEX;
        end else if (is_digit(b)) begin
          shape = TR_NUM;
        end else if (b == DOT) begin
          shape = TR_NUM;
          dots  = 2'd1;
        end else begin
          shape = TR_WORD;
        end
      end
      TR_MINUS: shape = is_digit(b) ? TR_NUM : TR_WORD;
      TR_NUM: begin
        if (b == DOT) begin
          if (dots < 2'd2) dots++;
        end else if (!is_digit(b)) begin
          shape = TR_WORD;
        end
      end
      TR_HEX: begin
        if (!is_hex_digit(b)) shape = TR_WORD;
      end
      default: shape = TR_WORD;
    endcase
    if (open_length == 0 && b == QUOTE) quotes |= 2'b01;
    else if (open_length == 2 && b == QUOTE) quotes |= 2'b10;
    else if (open_length >= 3) quotes = 2'b00;
    if (open_length != '1) open_length++;
  endtask

  // Predict the effect of one byte transaction
  task automatic take_byte(input logic [7:0] b);
    token_result_t r;
    if (b == 8'd0) begin
      if (open_length != 0) begin
        r = close_token(1'b1);
      end else begin
        r.token_class  = CLS_NONE;
        r.token_line   = line_now;
        r.token_column = column_now;
        r.token_length = '0;
        r.end_of_input = 1'b1;
      end
      expected_tokens.push_back(r);
      clear_open();
      line_now   = first_line;
      column_now = first_column;
      fresh      = 1'b1;
    end else begin
      fresh = 1'b0;
      if (is_space(b)) begin
        if (open_length != 0) begin
          expected_tokens.push_back(close_token(1'b0));
          clear_open();
        end
      end else begin
        if (open_length == 0) begin
          open_line   = line_now;
          open_column = column_now;
          clear_open();
        end
        track(b);
      end
      // Advance the position, saturating both counters
      if (b == NEWLINE) begin
        column_now = '0;
        if (line_now != '1) line_now++;
      end else if (column_now != '1) begin
        column_now++;
      end
    end
  endtask

  task automatic report(input string why, input token_result_t want, input token_result_t got);
    mismatch_count++;
    if (mismatch_count <= REPORT_MAX) begin
      $display("%0t token %s: want class %0d line %0d col %0d len %0d end %0b",
               $realtime, why, want.token_class, want.token_line, want.token_column,
               want.token_length, want.end_of_input);
      $display("%0t          got  class %0d line %0d col %0d len %0d end %0b",
               $realtime, got.token_class, got.token_line, got.token_column,
               got.token_length, got.end_of_input);
    end
  endtask

  always @(posedge clk) begin : watch
    token_result_t want;
    token_result_t got;
    if (rst) begin
      first_line   = 16'd1;
      first_column = '0;
      line_now     = 16'd1;
      column_now   = '0;
      open_line    = '0;
      open_column  = '0;
      clear_open();
      fresh        = 1'b1;
      expected_tokens.delete();
    end else begin
      // Compare a result transaction with the oldest prediction
      if (token.valid && token.ready) begin
        got.token_class  = token_class_t'(token.token_class);
        got.token_line   = token.token_line;
        got.token_column = token.token_column;
        got.token_length = token.token_length;
        got.end_of_input = token.end_of_input;
        if (expected_tokens.size() == 0) begin
          want = '0;
          report("with nothing pending", want, got);
        end else begin
          want = expected_tokens.pop_front();
          if (got !== want) report("mismatch", want, got);
        end
      end
      // Register writes load the counters only while no byte has come since reset or end
      if (cfg_we) begin
        if (cfg_index == CFG_START_LINE) begin
          first_line = cfg_wdata[START_LINE_BITS-1:0];
          if (fresh) line_now = first_line;
        end else begin
          first_column = cfg_wdata[START_COLUMN_BITS-1:0];
          if (fresh) column_now = first_column;
        end
      end
      if (text.valid && text.ready) take_byte(text.text_byte);
    end
    failures <= mismatch_count;
    pending  <= expected_tokens.size();
  end

endmodule

// File: dv/testbench.sv
// Testbench top: clock, reset, byte stimulus, result-side stalls and the verdict.
`timescale 1ns / 1ps

module testbench;
  import wtc_pkg::*;

  localparam logic [7:0] TAB          = 8'h09;
  localparam logic [7:0] CR           = 8'h0D;
  localparam logic [7:0] SPACE        = 8'h20;
  localparam logic [7:0] QUOTE        = 8'h27;
  localparam logic [7:0] MINUS        = 8'h2D;
  localparam logic [7:0] DOT          = 8'h2E;
  localparam logic [7:0] DIGIT_ZERO   = 8'h30;
  localparam logic [7:0] END_OF_TEXT  = 8'h00;
  localparam int         PHASE_BYTES  = 320;
  localparam int         PHASES       = 6;
  localparam int         DRAIN_CYCLES = 6;
  localparam int         CYCLE_LIMIT  = 400000;

  logic clk;
  logic rst;
  logic                      cfg_we;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_wdata;

  wtc_byte_if  text_ch ();
  wtc_token_if token_ch ();

  int failures;
  int pending;
  int sent_bytes = 0;
  int burst_left = 0;
  int cycles     = 0;
  int stall_mode = 0;
  int stall_left = 0;
  logic [7:0] ready_pattern = 8'h00;

  string hex_chars   = "0123456789abcdefABCDEF";
  string radix_chars = "xXbB";
  string opening     = "'q' 0xA -7.5 1..2\r\n0 -\t";

  whitespace_token_classifier_top uut (
    .clk       (clk),
    .rst       (rst),
    .text      (text_ch),
    .token     (token_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  token_checker classify_check (
    .clk       (clk),
    .rst       (rst),
    .text      (text_ch),
    .token     (token_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .failures  (failures),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Result side: switch between stall patterns at random
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode    = $urandom_range(0, 3);
      stall_left    = $urandom_range(16, 96);
      ready_pattern = 8'($urandom);
    end
    stall_left--;
    ready_pattern = {ready_pattern[6:0], ready_pattern[7]};
    case (stall_mode)
      0:       token_ch.ready <= 1'b1;
      1:       token_ch.ready <= 1'($urandom_range(0, 1));
      2:       token_ch.ready <= ready_pattern[0];
      default: token_ch.ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  function automatic logic [7:0] word_byte();
    if ($urandom_range(0, 3) != 0) return 8'($urandom_range(33, 126));
    return 8'($urandom_range(128, 255));
  endfunction

  function automatic logic [7:0] digit_byte();
    return DIGIT_ZERO + 8'($urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] blank_byte();
    if ($urandom_range(0, 2) != 0) return SPACE;
    return 8'($urandom_range(TAB, CR));
  endfunction

  // Drive one byte transaction, opening a new burst after a random gap
  task automatic send_byte(input logic [7:0] b);
    if (burst_left == 0) begin
      text_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    burst_left--;
    text_ch.valid     <= 1'b1;
    text_ch.text_byte <= b;
    @(posedge clk);
    while (!text_ch.ready) @(posedge clk);
    sent_bytes++;
  endtask

  // Drop valid, wait for every predicted token, then let the pipeline drain
  task automatic settle();
    text_ch.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_start(input logic [15:0] line_v, input logic [15:0] column_v);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_START_LINE;
    cfg_wdata <= line_v;
    @(posedge clk);
    cfg_index <= CFG_START_COLUMN;
    cfg_wdata <= column_v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // One token of a random shape followed by a separator
  task automatic send_token();
    int kind;
    int n;
    kind = $urandom_range(0, 11);
    case (kind)
      0: begin
        send_byte(QUOTE);
        send_byte(word_byte());
        send_byte(QUOTE);
      end
      1: begin
        send_byte(DIGIT_ZERO);
        send_byte(radix_chars[$urandom_range(0, 3)]);
        repeat ($urandom_range(0, 6)) send_byte(hex_chars[$urandom_range(0, 21)]);
        if ($urandom_range(0, 4) == 0) send_byte(word_byte());
      end
      2: begin
        if ($urandom_range(0, 1)) send_byte(MINUS);
        repeat ($urandom_range(1, 8)) send_byte(digit_byte());
      end
      3: begin
        if ($urandom_range(0, 1)) send_byte(MINUS);
        repeat ($urandom_range(1, 4)) send_byte(digit_byte());
        send_byte(DOT);
        repeat ($urandom_range(0, 4)) send_byte(digit_byte());
        if ($urandom_range(0, 3) == 0) begin
          send_byte(DOT);
          send_byte(digit_byte());
        end
      end
      4: begin
        send_byte(DIGIT_ZERO);
        case ($urandom_range(0, 4))
          0: ;
          1: send_byte(digit_byte());
          2: send_byte(DOT);
          3: begin
            send_byte(DOT);
            send_byte(digit_byte());
          end
          default: begin
            send_byte(DOT);
            send_byte(DOT);
          end
        endcase
      end
      5: begin
        send_byte(MINUS);
        case ($urandom_range(0, 3))
          0: ;
          1: send_byte(MINUS);
          2: send_byte(word_byte());
          default: begin
            send_byte(DOT);
            send_byte(digit_byte());
          end
        endcase
      end
      6, 7: repeat ($urandom_range(1, 10)) send_byte(word_byte());
      8: begin
        case ($urandom_range(0, 5))
          0: send_byte(QUOTE);
          1: begin
            send_byte(QUOTE);
            send_byte(QUOTE);
          end
          2: begin
            send_byte(QUOTE);
            send_byte(word_byte());
            send_byte(word_byte());
            send_byte(QUOTE);
          end
          3: begin
            send_byte(QUOTE);
            send_byte(word_byte());
          end
          4: begin
            send_byte(word_byte());
            send_byte(QUOTE);
            send_byte(word_byte());
          end
          default: repeat (3) send_byte(QUOTE);
        endcase
      end
      9: repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(1, 255)));
      10: begin
        // Rarely a token long enough to saturate the length
        if ($urandom_range(0, 39) == 0) begin
          n = $urandom_range(256, 300);
          if ($urandom_range(0, 1)) repeat (n) send_byte(digit_byte());
          else repeat (n) send_byte(word_byte());
        end else begin
          repeat ($urandom_range(1, 3)) send_byte(word_byte());
        end
      end
      default: send_byte(END_OF_TEXT);
    endcase
    if ($urandom_range(0, 11) == 0) send_byte(END_OF_TEXT);
    else repeat ($urandom_range(1, 3)) send_byte(blank_byte());
  endtask

  // Give up if the run hangs
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int target;
    rst               <= 1'b1;
    cfg_we            <= 1'b0;
    cfg_index         <= CFG_START_LINE;
    cfg_wdata         <= '0;
    text_ch.valid     <= 1'b0;
    text_ch.text_byte <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed tokens at the reset start values
    for (int i = 0; i < opening.len(); i++) send_byte(opening[i]);
    send_byte(8'hFF);
    send_byte(QUOTE);
    send_byte(QUOTE);
    send_byte(END_OF_TEXT);
    send_byte(END_OF_TEXT);
    settle();

    // Random phases, each with its own start values
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: set_start(16'h0000, 16'h0000);
        1: set_start(16'hFFFF, 16'hFFFF);
        3: set_start(16'hFFFE, 16'h0FFE);
        5: set_start(16'h0001, 16'h0000);
        default: set_start(16'($urandom), 16'($urandom));
      endcase
      target = sent_bytes + PHASE_BYTES;
      while (sent_bytes < target) send_token();
      // Odd phases end mid-stream so the next write is deferred
      if (phase % 2 == 0) send_byte(END_OF_TEXT);
      else send_byte(SPACE);
      settle();
    end
    send_byte(END_OF_TEXT);
    settle();

    if (failures == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
